>>> rtl/crbr_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Card response bit realigner: shared package
// Field widths, status and register codes, transaction structs and the
// leading-ones helper used by the alignment stage.
// ---------------------------------------------------------------------------
package crbr_pkg;

   localparam int BYTE_W  = 8;
   localparam int LEN_W   = 6;
   localparam int LIMIT_W = 16;
   localparam int INDEX_W = 2;

   localparam logic [BYTE_W-1:0] IDLE_BYTE = 8'hff;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_TIMEOUT  = 2'd1,
      STATUS_LINK_ERR = 2'd2
   } status_type;

   localparam logic [INDEX_W-1:0] REG_RESPONSE_BYTES = 2'd0;
   localparam logic [INDEX_W-1:0] REG_START_LIMIT    = 2'd1;
   localparam logic [INDEX_W-1:0] REG_TOTAL_LIMIT    = 2'd2;

   typedef struct packed {
      logic [BYTE_W-1:0] rx_byte;
      logic              link_error;
   } req_item_type;

   typedef struct packed {
      logic         valid;
      req_item_type item;
   } stage_type;

   typedef struct packed {
      logic [LEN_W-1:0]   response_bytes;
      logic [LIMIT_W-1:0] start_limit;
      logic [LIMIT_W-1:0] total_limit;
   } cfg_type;

   // Leading ones of a byte, counting at most seven.
   function automatic logic [2:0] lead_ones(input logic [BYTE_W-1:0] b);
      logic [2:0] n;
      logic       run;
      n   = 3'd0;
      run = 1'b1;
      for (int i = BYTE_W - 1; i >= 1; i--) begin
         if (run && b[i]) begin
            n = n + 3'd1;
         end else begin
            run = 1'b0;
         end
      end
      return n;
   endfunction

endpackage

>>> rtl/crbr_ifs.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Card response bit realigner: channel interfaces
// Valid/ready channels for received bytes, results and register writes.
// ---------------------------------------------------------------------------
interface crbr_req_if import crbr_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] rx_byte;
   logic              link_error;

   modport source (output valid, output rx_byte, output link_error, input ready);
   modport sink (input valid, input rx_byte, input link_error, output ready);
endinterface

interface crbr_rsp_if import crbr_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;
   logic [1:0]        status;
   logic              last;

   modport source (output valid, output data_byte, output status, output last,
                   input ready);
   modport sink (input valid, input data_byte, input status, input last,
                 output ready);
endinterface

interface crbr_csr_if import crbr_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [INDEX_W-1:0] index;
   logic [LIMIT_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/crbr_csr.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Card response bit realigner: configuration registers
// Holds the response length and the two wait limits.
// ---------------------------------------------------------------------------
module crbr_csr import crbr_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   crbr_csr_if.sink      csr_ch,
   output cfg_type       cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ch.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         case (csr_ch.index)
            REG_RESPONSE_BYTES: cfg_in.response_bytes = csr_ch.data[LEN_W-1:0];
            REG_START_LIMIT:    cfg_in.start_limit    = csr_ch.data;
            REG_TOTAL_LIMIT:    cfg_in.total_limit    = csr_ch.data;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.response_bytes <= LEN_W'(6);
         cfg_ff.start_limit    <= LIMIT_W'(1024);
         cfg_ff.total_limit    <= LIMIT_W'(1024);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> rtl/crbr_in_reg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Card response bit realigner: input register
// Captures one received byte per cycle and holds it while the result side
// is stalled.
// ---------------------------------------------------------------------------
module crbr_in_reg import crbr_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   crbr_req_if.sink      req_ch,
   input  logic          advance,
   output stage_type     stage
);

   logic         valid_ff;
   logic         valid_in;
   req_item_type item_ff;
   logic         fire;

   assign req_ch.ready = !valid_ff || advance;
   assign fire         = req_ch.valid && req_ch.ready;

   always_comb begin
      valid_in = valid_ff;
      if (fire) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         item_ff.rx_byte    <= req_ch.rx_byte;
         item_ff.link_error <= req_ch.link_error;
      end
   end

   assign stage.valid = valid_ff;
   assign stage.item  = item_ff;

endmodule

>>> rtl/crbr_align.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Card response bit realigner: alignment stage
// Start-bit hunting, shift-merge of byte pairs, wait counting and the
// result register.
// ---------------------------------------------------------------------------
module crbr_align import crbr_pkg::*; #(
   parameter int MAX_RESPONSE_BYTES = 32,
   parameter int WAIT_COUNT_BITS    = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  cfg_type       cfg,
   input  stage_type     stage,
   output logic          advance,
   crbr_rsp_if.source    rsp_ch
);

   localparam int POS_W = $clog2(MAX_RESPONSE_BYTES + 1);
   localparam int CMP_L = (POS_W > LEN_W) ? POS_W : LEN_W;
   localparam int CMP_W = (WAIT_COUNT_BITS > LIMIT_W) ? WAIT_COUNT_BITS : LIMIT_W;
   localparam logic [CMP_L-1:0] MAX_LEN = CMP_L'(MAX_RESPONSE_BYTES);

   logic                       collecting_ff, collecting_in;
   logic [2:0]                 offset_ff, offset_in;
   logic [BYTE_W-1:0]          prev_ff, prev_in;
   logic [POS_W-1:0]           pos_ff, pos_in;
   logic [WAIT_COUNT_BITS-1:0] wait_ff, wait_in;

   logic                       out_valid_ff, out_valid_in;
   logic [BYTE_W-1:0]          out_data_ff;
   status_type                 out_status_ff;
   logic                       out_last_ff;

   logic                       load;
   logic [BYTE_W-1:0]          res_data;
   status_type                 res_status;
   logic                       res_last;

   logic                       step;
   logic [WAIT_COUNT_BITS-1:0] count_inc;
   logic [CMP_W-1:0]           old_cmp, new_cmp, start_cmp, total_cmp;
   logic [CMP_L-1:0]           cfg_len, length, pos_next;
   logic [2*BYTE_W-1:0]        pair;

   assign advance   = !out_valid_ff || rsp_ch.ready;
   assign step      = stage.valid && advance;
   assign count_inc = wait_ff + WAIT_COUNT_BITS'(1);
   assign old_cmp   = CMP_W'(wait_ff);
   assign new_cmp   = CMP_W'(count_inc);
   assign start_cmp = CMP_W'(cfg.start_limit);
   assign total_cmp = CMP_W'(cfg.total_limit);
   assign cfg_len   = CMP_L'(cfg.response_bytes);
   assign length    = (cfg_len > MAX_LEN) ? MAX_LEN : cfg_len;
   assign pos_next  = CMP_L'(pos_ff) + CMP_L'(1);
   assign pair      = {prev_ff, stage.item.rx_byte} << offset_ff;

   always_comb begin
      collecting_in = collecting_ff;
      offset_in     = offset_ff;
      prev_in       = prev_ff;
      pos_in        = pos_ff;
      wait_in       = wait_ff;
      load          = 1'b0;
      res_data      = IDLE_BYTE;
      res_status    = STATUS_OK;
      res_last      = 1'b0;

      if (step) begin
         wait_in = count_inc;
         if (stage.item.link_error) begin
            load       = 1'b1;
            res_status = STATUS_LINK_ERR;
            res_last   = 1'b1;
         end else if (!collecting_ff) begin
            if (old_cmp > start_cmp) begin
               load       = 1'b1;
               res_status = STATUS_TIMEOUT;
               res_last   = 1'b1;
            end else if (stage.item.rx_byte != IDLE_BYTE) begin
               offset_in     = lead_ones(stage.item.rx_byte);
               prev_in       = stage.item.rx_byte;
               pos_in        = '0;
               collecting_in = 1'b1;
            end
         end else begin
            load    = 1'b1;
            prev_in = stage.item.rx_byte;
            if ((old_cmp < total_cmp) && (pos_next < length)) begin
               res_data = pair[2*BYTE_W-1:BYTE_W];
               pos_in   = pos_next[POS_W-1:0];
            end else begin
               res_last = 1'b1;
               if (new_cmp < start_cmp) begin
                  res_data = pair[2*BYTE_W-1:BYTE_W];
               end else begin
                  res_status = STATUS_TIMEOUT;
               end
            end
         end

         if (res_last) begin
            collecting_in = 1'b0;
            offset_in     = 3'd0;
            prev_in       = IDLE_BYTE;
            pos_in        = '0;
            wait_in       = '0;
         end
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (load) begin
         out_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         collecting_ff <= 1'b0;
         offset_ff     <= 3'd0;
         prev_ff       <= IDLE_BYTE;
         pos_ff        <= '0;
         wait_ff       <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         collecting_ff <= collecting_in;
         offset_ff     <= offset_in;
         prev_ff       <= prev_in;
         pos_ff        <= pos_in;
         wait_ff       <= wait_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_data_ff   <= res_data;
         out_status_ff <= res_status;
         out_last_ff   <= res_last;
      end
   end

   assign rsp_ch.valid     = out_valid_ff;
   assign rsp_ch.data_byte = out_data_ff;
   assign rsp_ch.status    = out_status_ff;
   assign rsp_ch.last      = out_last_ff;

   // Every failed response ends at once and carries an idle data byte.
   a_error_is_final: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && (out_status_ff != STATUS_OK) |-> out_last_ff && (out_data_ff == IDLE_BYTE))
      else $error("error result without last or with data");

   // A final result always leaves the block hunting with a cleared counter.
   a_final_clears: assert property (@(posedge clock) disable iff (reset)
      load && res_last |=> !collecting_ff && (wait_ff == '0))
      else $error("state not cleared after final result");

   // While hunting, the alignment state stays at its idle values.
   a_hunt_idle: assert property (@(posedge clock) disable iff (reset)
      !collecting_ff |-> (pos_ff == '0) && (offset_ff == 3'd0) && (prev_ff == IDLE_BYTE))
      else $error("alignment state not idle while hunting");

   // The position never reaches the saturated response length.
   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      collecting_ff |-> CMP_L'(pos_ff) < MAX_LEN)
      else $error("position beyond response length");

   // A result held under stall is not overwritten.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_ch.ready |-> !load)
      else $error("result register overwritten while stalled");

endmodule

>>> rtl/card_response_bit_realigner_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Card response bit realigner
// Realigns bytes from a card command line to the start bit of a response.
//
//   Channel   Direction   Payload                        Transaction
//   req_ch    in          rx_byte, link_error            one received byte
//   rsp_ch    out         data_byte, status, last        one response result
//   csr_ch    in          index, data                    one register write
//
// A received byte passes the input register and the alignment stage, whose
// result register offers results; one byte per cycle goes in unless stalled.
// Reset clears hunting state and wait counter and loads register defaults.
// A stalled result holds the alignment stage and then the input register.
// ---------------------------------------------------------------------------
module card_response_bit_realigner_core import crbr_pkg::*; #(
   parameter int MAX_RESPONSE_BYTES = 32,
   parameter int WAIT_COUNT_BITS    = 16
) (
   input  logic          clock,
   input  logic          reset,
   crbr_req_if.sink      req_ch,
   crbr_rsp_if.source    rsp_ch,
   crbr_csr_if.sink      csr_ch
);

   cfg_type   cfg;
   stage_type stage;
   logic      advance;

   crbr_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .cfg    (cfg)
   );

   crbr_in_reg u_in_reg (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .advance (advance),
      .stage   (stage)
   );

   crbr_align #(
      .MAX_RESPONSE_BYTES (MAX_RESPONSE_BYTES),
      .WAIT_COUNT_BITS    (WAIT_COUNT_BITS)
   ) u_align (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .stage   (stage),
      .advance (advance),
      .rsp_ch  (rsp_ch)
   );

endmodule
